// ===== design/bhpq_pkg.sv =====
// Shared field widths, request codes and status codes of the binary heap priority queue.
package bhpq_pkg;

    localparam int REQ_W  = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [REQ_W-1:0]  req_code_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam req_code_t REQ_INSERT = 2'd0;
    localparam req_code_t REQ_REMOVE = 2'd1;
    localparam req_code_t REQ_READ   = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_OUT_RANGE = 2'd3;

    // Register index of the ordering mode register.
    localparam logic REG_ORDER_MODE = 1'b0;

endpackage

// ===== design/bhpq_req_if.sv =====
// Request channel interface: valid/ready handshake with the request payload.
interface bhpq_req_if;
    logic                       valid;
    logic                       ready;
    logic [bhpq_pkg::REQ_W-1:0] req_type;
    logic [bhpq_pkg::KEY_W-1:0] key;
    logic [bhpq_pkg::POS_W-1:0] position;

    modport source (output valid, output req_type, output key, output position, input ready);
    modport sink (input valid, input req_type, input key, input position, output ready);
endinterface

// ===== design/bhpq_rsp_if.sv =====
// Result channel interface: valid/ready handshake with the result payload.
interface bhpq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bhpq_pkg::KEY_W-1:0]  root_key;
    logic                        root_valid;
    logic [bhpq_pkg::CNT_W-1:0]  entry_count;
    logic [bhpq_pkg::KEY_W-1:0]  read_data;
    logic [bhpq_pkg::STAT_W-1:0] status;

    modport source (output valid, output root_key, output root_valid, output entry_count,
                    output read_data, output status, input ready);
    modport sink (input valid, input root_key, input root_valid, input entry_count,
                  input read_data, input status, output ready);
endinterface

// ===== design/bhpq_cmp.sv =====
// Shared key comparator: tells whether key a strictly beats key b under the ordering mode.
module bhpq_cmp #(
    parameter int KW = 32
) (
    input  logic [KW-1:0] a,
    input  logic [KW-1:0] b,
    input  logic          order_mode,
    output logic          beats
);

    // Mode 0 keeps the largest key on top, mode 1 the smallest. Ties never win.
    assign beats = order_mode ? (a < b) : (a > b);

endmodule

// ===== design/bhpq_mem.sv =====
// Heap key storage: one write port and one read port with registered read data.
module bhpq_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bhpq_apb.sv =====
// APB register slave holding the ordering mode register.
module bhpq_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhpq_pkg::APB_AW-1:0] paddr,
    input  logic [bhpq_pkg::APB_DW-1:0] pwdata,
    output logic [bhpq_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic                        order_mode
);

    logic mode_reg;
    logic hit;

    // Registers sit on 4-byte boundaries, so bit 2 of the address is the register index.
    assign hit    = (paddr[2] == bhpq_pkg::REG_ORDER_MODE);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && hit)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata     = hit ? {{(bhpq_pkg::APB_DW-1){1'b0}}, mode_reg} : '0;
    assign order_mode = mode_reg;

endmodule

// ===== design/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: sequencer, heap storage and comparator.
//
// Usage: requests arrive as transactions on the req channel (insert a key, remove the root,
// or read the entry at an array position) and each request yields exactly one transaction on
// the rsp channel carrying the root key, the entry count, the read data and a status.
// The ordering mode (largest or smallest key on top) is written through the APB port at
// byte address 0; it should only be changed while no request is in flight.
// A read waits for the registered memory read; an insert climbs one level per comparison
// with its parent; a remove moves the last entry to the root and sinks it, each level
// taking the steps read left child, read right child, compare and write. A request that
// moves nothing in the tree (full insert, first insert, empty remove, remove of the last
// entry, out-of-range read, unused code) goes straight to its result. The sequencer is
// ready for the next request in the cycle after the result is loaded, so one request is
// worked on at a time, its pace set by the single read port of the heap memory and the
// one shared comparator.
// Reset clears the entry count and the mode; the heap memory itself is not cleared, since
// only positions below the count are ever read.
// The result sits in an output register: a new request is taken while a finished result
// still waits, and the sequencer only holds in its final step if a second result is ready
// before the receiver has taken the first.
module binary_heap_priority_queue #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bhpq_req_if.sink                    req,
    bhpq_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhpq_pkg::APB_AW-1:0] paddr,
    input  logic [bhpq_pkg::APB_DW-1:0] pwdata,
    output logic [bhpq_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LW   = AW + 1;
    localparam int CMPW = (CW > bhpq_pkg::POS_W) ? CW : bhpq_pkg::POS_W;
    localparam int KW   = KEY_WIDTH;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_PUT     = 4'd3;
    localparam logic [3:0] S_DN_LAST = 4'd4;
    localparam logic [3:0] S_DN_RDL  = 4'd5;
    localparam logic [3:0] S_DN_RDR  = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_RD_WAIT = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]                     state_reg, state_next;
    bhpq_pkg::req_code_t            req_reg, req_next;
    logic [bhpq_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [KW-1:0]                  cur_reg, cur_next;
    logic [KW-1:0]                  best_val_reg, best_val_next;
    logic                           best_left_reg, best_left_next;
    logic                           have_right_reg, have_right_next;
    logic [AW-1:0]                  node_reg, node_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [KW-1:0]                  root_reg;
    logic [KW-1:0]                  rdata_reg, rdata_next;
    bhpq_pkg::status_t              status_reg, status_next;

    logic                           out_valid_reg;
    logic [bhpq_pkg::KEY_W-1:0]     out_root_reg;
    logic                           out_rvalid_reg;
    logic [bhpq_pkg::CNT_W-1:0]     out_cnt_reg;
    logic [bhpq_pkg::KEY_W-1:0]     out_rdata_reg;
    bhpq_pkg::status_t              out_status_reg;
    logic                           out_load;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [KW-1:0]                  mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic [KW-1:0]                  mem_rdata;

    logic [KW-1:0]                  cmp_a, cmp_b;
    logic                           cmp_beats;
    logic                           order_mode;

    logic [AW-1:0]                  parent;
    logic [LW-1:0]                  left_idx, right_idx;

    bhpq_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .order_mode (order_mode)
    );

    bhpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (KW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bhpq_cmp #(
        .KW (KW)
    ) u_cmp (
        .a          (cmp_a),
        .b          (cmp_b),
        .order_mode (order_mode),
        .beats      (cmp_beats)
    );

    // Tree navigation for the current node. Children are one bit wider so that an index
    // past the end of the array is still seen as such.
    assign parent    = (node_reg - AW'(1)) >> 1;
    assign left_idx  = {node_reg, 1'b1};
    assign right_idx = left_idx + LW'(1);

    // The single comparator is steered by the state: climbing compares the new key with
    // its parent, sinking first compares the left child with the moving key and then the
    // right child with whichever of those two won.
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg;
                cmp_b = mem_rdata;
            end
            S_DN_RDR:
            begin
                cmp_a = mem_rdata;
                cmp_b = cur_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = mem_rdata;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = cur_reg;
                cmp_b = mem_rdata;
            end
        endcase
    end

    // The moving key is held in cur_reg and only written once it settles; every step on the
    // way moves one neighbor into the hole, which gives the same array as repeated swaps.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        best_val_next   = best_val_reg;
        best_left_next  = best_left_reg;
        have_right_next = have_right_reg;
        node_next       = node_reg;
        count_next      = count_reg;
        rdata_next      = rdata_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = node_reg;
        mem_wdata       = cur_reg;
        mem_raddr       = '0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next   = req.req_type;
                    pos_next   = req.position;
                    cur_next   = KW'(req.key);
                    state_next = S_START;
                end
            end

            S_START:
            begin
                rdata_next  = '0;
                status_next = bhpq_pkg::ST_OK;
                state_next  = S_DONE;
                case (req_reg)
                    bhpq_pkg::REQ_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = bhpq_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            node_next  = AW'(count_reg);
                            mem_raddr  = AW'((count_reg - CW'(1)) >> 1);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_CMP;
                        end
                    end
                    bhpq_pkg::REQ_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bhpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (count_reg != CW'(1))
                            begin
                                mem_raddr  = AW'(count_reg - CW'(1));
                                state_next = S_DN_LAST;
                            end
                        end
                    end
                    bhpq_pkg::REQ_READ:
                    begin
                        if (CMPW'(pos_reg) < CMPW'(count_reg))
                        begin
                            mem_raddr  = AW'(pos_reg);
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            status_next = bhpq_pkg::ST_OUT_RANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_UP_CMP:
            begin
                if (cmp_beats)
                begin
                    // The parent moves down into the hole and the key climbs one level.
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    node_next = parent;
                    if (parent == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_raddr = (parent - AW'(1)) >> 1;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DN_LAST:
            begin
                cur_next   = mem_rdata;
                node_next  = '0;
                state_next = S_DN_RDL;
            end

            S_DN_RDL:
            begin
                if (left_idx >= LW'(count_reg))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_raddr  = AW'(left_idx);
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                best_left_next = cmp_beats;
                best_val_next  = cmp_beats ? mem_rdata : cur_reg;
                if (right_idx < LW'(count_reg))
                begin
                    mem_raddr       = AW'(right_idx);
                    have_right_next = 1'b1;
                end
                else
                begin
                    have_right_next = 1'b0;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (have_right_reg && cmp_beats)
                begin
                    mem_wdata  = mem_rdata;
                    node_next  = AW'(right_idx);
                    state_next = S_DN_RDL;
                end
                else if (best_left_reg)
                begin
                    mem_wdata  = best_val_reg;
                    node_next  = AW'(left_idx);
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RD_WAIT:
            begin
                rdata_next = mem_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        best_val_reg   <= best_val_next;
        best_left_reg  <= best_left_next;
        have_right_reg <= have_right_next;
        node_reg       <= node_next;
        rdata_reg      <= rdata_next;
        status_reg     <= status_next;
        // A copy of the root keeps the result from needing a memory read.
        if (mem_we && (mem_waddr == '0))
        begin
            root_reg <= mem_wdata;
        end
        if (out_load)
        begin
            out_root_reg   <= (count_reg != '0) ? bhpq_pkg::KEY_W'(root_reg) : '0;
            out_rvalid_reg <= (count_reg != '0);
            out_cnt_reg    <= bhpq_pkg::CNT_W'(count_reg);
            out_rdata_reg  <= bhpq_pkg::KEY_W'(rdata_reg);
            out_status_reg <= status_reg;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.root_key    = out_root_reg;
    assign rsp.root_valid  = out_rvalid_reg;
    assign rsp.entry_count = out_cnt_reg;
    assign rsp.read_data   = out_rdata_reg;
    assign rsp.status      = out_status_reg;

endmodule

// ===== bench/heap_check_pkg.sv =====
// Result type and the heap tracker class that predicts and checks priority queue results.
package heap_check_pkg;

    localparam int HEAP_DEPTH = 1024;

    // The request code the block leaves unused; it must still answer it.
    localparam bhpq_pkg::req_code_t REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [bhpq_pkg::KEY_W-1:0] root_key;
        logic                       root_valid;
        logic [bhpq_pkg::CNT_W-1:0] entry_count;
        logic [bhpq_pkg::KEY_W-1:0] read_data;
        bhpq_pkg::status_t          status;
    } heap_result_t;

    class heap_tracker;
        logic [bhpq_pkg::KEY_W-1:0] keys [HEAP_DEPTH];
        int unsigned                fill;
        bit                         smallest_on_top;
        heap_result_t               awaited_results [$];
        int unsigned                errors;

        function new();
            fill = 0;
            smallest_on_top = 1'b0;
            errors = 0;
        endfunction

        function void set_order(bit smallest);
            smallest_on_top = smallest;
        endfunction

        function bit beats(logic [bhpq_pkg::KEY_W-1:0] a, logic [bhpq_pkg::KEY_W-1:0] b);
            return smallest_on_top ? (a < b) : (a > b);
        endfunction

        function void exchange(int unsigned i, int unsigned j);
            logic [bhpq_pkg::KEY_W-1:0] held;
            held = keys[i];
            keys[i] = keys[j];
            keys[j] = held;
        endfunction

        // Applies one accepted request to the tracked heap and queues the result it must give.
        function void note_request(bhpq_pkg::req_code_t kind,
                                   logic [bhpq_pkg::KEY_W-1:0] key,
                                   logic [bhpq_pkg::POS_W-1:0] pos);
            heap_result_t r;
            int unsigned  node;
            int unsigned  parent;
            int unsigned  left;
            int unsigned  best;
            r.read_data = '0;
            r.status = bhpq_pkg::ST_OK;
            case (kind)
                bhpq_pkg::REQ_INSERT:
                begin
                    if (fill >= HEAP_DEPTH)
                    begin
                        r.status = bhpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        keys[fill] = key;
                        node = fill;
                        while (node > 0)
                        begin
                            parent = (node - 1) / 2;
                            if (!beats(keys[node], keys[parent]))
                                break;
                            exchange(node, parent);
                            node = parent;
                        end
                        fill++;
                    end
                end
                bhpq_pkg::REQ_REMOVE:
                begin
                    if (fill == 0)
                    begin
                        r.status = bhpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fill--;
                        exchange(0, fill);
                        node = 0;
                        forever
                        begin
                            left = 2 * node + 1;
                            best = node;
                            if (left < fill && beats(keys[left], keys[best]))
                                best = left;
                            if (left + 1 < fill && beats(keys[left + 1], keys[best]))
                                best = left + 1;
                            if (best == node)
                                break;
                            exchange(node, best);
                            node = best;
                        end
                    end
                end
                bhpq_pkg::REQ_READ:
                begin
                    if (pos < fill)
                        r.read_data = keys[pos];
                    else
                        r.status = bhpq_pkg::ST_OUT_RANGE;
                end
                default:
                begin
                end
            endcase
            r.root_valid = (fill > 0);
            r.root_key = (fill > 0) ? keys[0] : '0;
            r.entry_count = bhpq_pkg::CNT_W'(fill);
            awaited_results.push_back(r);
        endfunction

        // Compares one accepted result with the oldest queued one, field by field.
        function void check_result(heap_result_t got);
            heap_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result transaction with none awaited: count %0d status %0d",
                       got.entry_count, got.status);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.root_key !== want.root_key)
            begin
                $error("root_key: expected %h, got %h", want.root_key, got.root_key);
                errors++;
            end
            if (got.root_valid !== want.root_valid)
            begin
                $error("root_valid: expected %b, got %b", want.root_valid, got.root_valid);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level testbench of the binary heap priority queue: stimulus, handshakes and checking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 4;
    // Cycles without any accepted transaction before the run is declared hung. The
    // slowest legal wait is the long receiver hold-off below plus a deep remove.
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bhpq_pkg::APB_AW-1:0] paddr;
    logic [bhpq_pkg::APB_DW-1:0] pwdata;
    logic [bhpq_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    bhpq_req_if req_ch ();
    bhpq_rsp_if rsp_ch ();

    binary_heap_priority_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Idling odds in percent for the sender and the receiver, changed per phase.
    int                           idle_pct;
    int                           stall_pct;
    // Set by the stimulus to make the receiver hold off; the receiver counts the stretch.
    bit                           hold_request;
    bit                           hold_taken = 1'b0;
    int                           hold_left = 0;
    int                           quiet_cycles = 0;
    heap_check_pkg::heap_result_t seen;
    heap_check_pkg::heap_tracker  tracker;

    always #(CLK_HALF) clk = ~clk;

    // Receiver: checks each accepted result transaction and decides ready for the next
    // cycle. Values read right after the edge are the ones the edge sampled.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                seen.root_key    = rsp_ch.root_key;
                seen.root_valid  = rsp_ch.root_valid;
                seen.entry_count = rsp_ch.entry_count;
                seen.read_data   = rsp_ch.read_data;
                seen.status      = rsp_ch.status;
                tracker.check_result(seen);
            end
            if (hold_request && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: any accepted transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("binary_heap_priority_queue test failed");
            $finish;
        end
    end

    // Writes the ordering mode with an APB setup and access cycle.
    task automatic write_order(bit smallest);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bhpq_pkg::APB_AW'(4 * bhpq_pkg::REG_ORDER_MODE);
        pwdata  <= bhpq_pkg::APB_DW'(smallest);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_order(smallest);
    endtask

    // Offers one request after a random gap and returns once it has been accepted.
    // Valid stays high on return so back-to-back requests need no extra edge.
    task automatic send_request(bhpq_pkg::req_code_t kind, logic [bhpq_pkg::KEY_W-1:0] k,
                                logic [bhpq_pkg::POS_W-1:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key      <= k;
        req_ch.position <= p;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_request(kind, k, p);
    endtask

    // Lets every awaited result arrive so that the mode can be changed safely. The sequencer
    // is already idle once its last result is loaded; the short pause only adds margin.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Keys mix the full range, a narrow band that makes ties common, and the extremes.
    function automatic logic [bhpq_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $urandom_range(15);
        else
            return $urandom_range(1) ? {bhpq_pkg::KEY_W{1'b1}} : {bhpq_pkg::KEY_W{1'b0}};
    endfunction

    // Any position in the field's range, for requests that ignore it.
    function automatic logic [bhpq_pkg::POS_W-1:0] any_position();
        return bhpq_pkg::POS_W'($urandom);
    endfunction

    // Most reads hit a filled position; the rest land anywhere in the field's range.
    function automatic logic [bhpq_pkg::POS_W-1:0] pick_position();
        if (tracker.fill > 0 && $urandom_range(99) < 85)
            return bhpq_pkg::POS_W'($urandom_range(tracker.fill - 1));
        return any_position();
    endfunction

    // Random traffic: inserts at the given odds, then removes, reads and a few unused codes.
    task automatic run_mixed(int items, int insert_pct);
        int r;
        repeat (items)
        begin
            r = $urandom_range(99);
            if (r < insert_pct)
                send_request(bhpq_pkg::REQ_INSERT, pick_key(), any_position());
            else if (r < insert_pct + 25)
                send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());
            else if (r < 97)
                send_request(bhpq_pkg::REQ_READ, $urandom, pick_position());
            else
                send_request(heap_check_pkg::REQ_UNUSED, $urandom, any_position());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = bhpq_pkg::REQ_INSERT;
        req_ch.key      = '0;
        req_ch.position = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_request    = 1'b0;
        tracker         = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, largest key on top after reset. An empty heap must refuse a
        // remove and a read, and an unused request code must change nothing.
        send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());
        send_request(bhpq_pkg::REQ_READ, $urandom, '0);
        send_request(heap_check_pkg::REQ_UNUSED, $urandom, any_position());
        // Key extremes, a tie that must not move, and the top bit alone.
        send_request(bhpq_pkg::REQ_INSERT, '0, any_position());
        send_request(bhpq_pkg::REQ_INSERT, {bhpq_pkg::KEY_W{1'b1}}, any_position());
        send_request(bhpq_pkg::REQ_INSERT, 32'd5, any_position());
        send_request(bhpq_pkg::REQ_INSERT, 32'd5, any_position());
        send_request(bhpq_pkg::REQ_INSERT, 32'h8000_0000, any_position());
        send_request(bhpq_pkg::REQ_INSERT, 32'd1, any_position());
        // Reads at the root, at the last filled slot, just past it, and at the top position.
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'd0);
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'd5);
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'd6);
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'h3FF);
        repeat (3) send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());

        // Switch to smallest on top while entries are held: they are not reordered,
        // and later requests compare the new way. Then empty the heap and go one past.
        wait_drained();
        write_order(1'b1);
        send_request(bhpq_pkg::REQ_INSERT, 32'd7, any_position());
        send_request(bhpq_pkg::REQ_INSERT, '0, any_position());
        send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'd0);
        repeat (5) send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());

        // Random phases, each with its own idling pattern and ordering mode.
        wait_drained();
        write_order(1'b0);
        run_mixed(150, 60);

        wait_drained();
        write_order(1'b1);
        idle_pct = 88;
        run_mixed(150, 45);

        wait_drained();
        write_order(1'b0);
        idle_pct = 0;
        stall_pct = 88;
        run_mixed(150, 60);

        wait_drained();
        write_order(1'b1);
        idle_pct = 37;
        stall_pct = 37;
        run_mixed(150, 45);

        // Back pressure: the receiver holds off for a long stretch while requests keep
        // coming, so the result register fills and the block stops taking requests.
        wait_drained();
        write_order(1'b0);
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        run_mixed(60, 60);

        // Grow a deep heap with smallest on top, with reads scattered through its levels.
        wait_drained();
        write_order(1'b1);
        idle_pct = 10;
        stall_pct = 10;
        repeat (120)
        begin
            if ($urandom_range(9) == 0)
                send_request(bhpq_pkg::REQ_READ, $urandom, pick_position());
            else
                send_request(bhpq_pkg::REQ_INSERT, pick_key(), any_position());
        end
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'h3FF);
        send_request(bhpq_pkg::REQ_READ, $urandom, 10'd0);

        // Flip the mode on the deep heap and sink new roots through its levels.
        wait_drained();
        write_order(1'b0);
        idle_pct = 37;
        stall_pct = 37;
        repeat (20)
        begin
            send_request(bhpq_pkg::REQ_REMOVE, $urandom, any_position());
            send_request(bhpq_pkg::REQ_READ, $urandom, pick_position());
        end

        // Wait for the last results, then give a late stray result time to show up.
        req_ch.valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.awaited_results.size() != 0)
            $error("%0d result transactions never arrived", tracker.awaited_results.size());
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0)
            $display("binary_heap_priority_queue test passed");
        else
            $display("binary_heap_priority_queue test failed");
        $finish;
    end

endmodule
